/* design/cdad_pkg.sv */
package cdad_pkg;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int DAYS_LONG       = 31;
   localparam int DAYS_SHORT      = 30;
   localparam int DAYS_FEB        = 28;
   localparam int DAYS_YEAR       = 365;
   localparam int YEARS_CYCLE     = 400;
   localparam int DAYS_CYCLE      = 146097;
   localparam int CYCLE_W         = 9;
   localparam int YEAR_FIELD_W    = 14;
   localparam int MONTH_W         = 4;
   localparam int DAY_W           = 5;

   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;
   typedef logic [CYCLE_W-1:0] cycle_pos_type;

   typedef struct packed {
      logic subtract;
   } alu_ctl_type;

   typedef struct packed {
      logic neg;
   } alu_flags_type;

   // leap test on the year's position within the 400-year cycle
   function automatic logic is_leap(input cycle_pos_type pos);
      logic century;
      century = (pos == cycle_pos_type'(100)) || (pos == cycle_pos_type'(200)) ||
                (pos == cycle_pos_type'(300));
      return (pos[1:0] == 2'b00) && !century;
   endfunction

   // zero for a month code outside 1..12
   function automatic day_type month_len(input month_type m, input logic leap);
      day_type len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = day_type'(DAYS_LONG);
         4'd4, 4'd6, 4'd9, 4'd11:                    len = day_type'(DAYS_SHORT);
         4'd2:    len = leap ? day_type'(DAYS_FEB + 1) : day_type'(DAYS_FEB);
         default: len = '0;
      endcase
      return len;
   endfunction

endpackage

/* design/calendar_date_add_days.sv */
// sequence: year mod 400, date check, day of year, add the offset, 400-year steps,
//   single-year steps, then the months of the result year (at most 11 months walked)
// one transaction at a time, set by the one shared adder in the year/month walk; a new
//   request is taken only once the result has gone to the output register
// reset: synchronous, active high; clears the sequencer and the result valid flag
module calendar_date_add_days #(
   parameter int OFFSET_BITS = 17,
   parameter int YEAR_MAX    = 9999
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[22+OFFSET_BITS:23]
   input  logic [((OFFSET_BITS + 30) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_year[13:0], result_month[17:14], result_day[22:18], zero pad[23]
   output logic [23:0] rsp_tdata,
   // input_invalid[0], range_hit[1]
   output logic [1:0]  rsp_tuser
);
   import cdad_pkg::*;

   // day count wide enough for the offset plus one 400-year cycle either way
   localparam int NW = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;
   // year register covers both the input field and the top year
   localparam int YW = $clog2(((YEAR_MAX > 16383) ? YEAR_MAX : 16383) + 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD  = 4'd1;   // year mod 400 by repeated subtraction
   localparam logic [3:0] S_CHK  = 4'd2;   // month and day range check
   localparam logic [3:0] S_DOY  = 4'd3;   // day of year, one month per cycle
   localparam logic [3:0] S_OFF  = 4'd4;   // add the offset
   localparam logic [3:0] S_YBIG = 4'd5;   // whole 400-year cycles
   localparam logic [3:0] S_YONE = 4'd6;   // single years
   localparam logic [3:0] S_MON  = 4'd7;   // months of the result year
   localparam logic [3:0] S_EMIT = 4'd8;   // hand over to the output register

   logic [3:0] state_ff, state_in;

   // working registers
   logic [YW-1:0]           year_ff, year_in;
   month_type               mon_ff, mon_in;
   day_type                 day_ff, day_in;
   logic [OFFSET_BITS-1:0]  off_ff, off_in;
   logic signed [NW-1:0]    n_ff, n_in;
   cycle_pos_type           pos_ff, pos_in;
   month_type               m_ff, m_in;

   // pending result
   logic [YEAR_FIELD_W-1:0] res_year_ff, res_year_in;
   month_type               res_mon_ff, res_mon_in;
   day_type                 res_day_ff, res_day_in;
   logic                    res_inv_ff, res_inv_in;
   logic                    res_rng_ff, res_rng_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [YEAR_FIELD_W-1:0] rsp_year_ff, rsp_year_in;
   month_type               rsp_mon_ff, rsp_mon_in;
   day_type                 rsp_day_ff, rsp_day_in;
   logic                    rsp_inv_ff, rsp_inv_in;
   logic                    rsp_rng_ff, rsp_rng_in;

   // shared adder
   logic signed [NW-1:0] alu_b, alu_sum;
   alu_ctl_type          alu_ctl;
   alu_flags_type        alu_flags;

   logic          n_neg, leap_cur, leap_dec, slot_free, date_ok;
   cycle_pos_type pos_dec, pos_inc;
   logic          over_cycle, over_one, over_top;

   cdad_alu #(
      .W(NW)
   ) u_alu (
      .op_a  (n_ff),
      .op_b  (alu_b),
      .ctl   (alu_ctl),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   assign n_neg    = n_ff[NW-1];
   assign pos_dec  = (pos_ff == '0) ? cycle_pos_type'(YEARS_CYCLE - 1) : pos_ff - 1'b1;
   assign pos_inc  = (pos_ff == cycle_pos_type'(YEARS_CYCLE - 1)) ? '0 : pos_ff + 1'b1;
   assign leap_cur = is_leap(pos_ff);
   assign leap_dec = is_leap(pos_dec);

   // would the next forward step leave the year range, or is the year already above it
   assign over_cycle = ({1'b0, year_ff} + (YW+1)'(YEARS_CYCLE)) > (YW+1)'(YEAR_MAX);
   assign over_one   = ({1'b0, year_ff} + (YW+1)'(1)) > (YW+1)'(YEAR_MAX);
   assign over_top   = year_ff > YW'(YEAR_MAX);

   // a zero month length from the table flags a bad month too
   assign date_ok   = (day_ff != '0) && (day_ff <= month_len(mon_ff, leap_cur));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // operand selection for the shared adder
   always_comb begin
      alu_b            = '0;
      alu_ctl.subtract = 1'b0;
      case (state_ff)
         S_MOD: begin
            alu_b            = NW'(YEARS_CYCLE);
            alu_ctl.subtract = 1'b1;
         end
         S_DOY: begin
            if (m_ff < mon_ff) begin
               alu_b = NW'(month_len(m_ff, leap_cur));
            end else begin
               alu_b = NW'(day_ff);
            end
         end
         S_OFF: begin
            alu_b = {{(NW - OFFSET_BITS){off_ff[OFFSET_BITS-1]}}, off_ff};
         end
         S_YBIG: begin
            alu_b            = NW'(DAYS_CYCLE);
            alu_ctl.subtract = !n_neg;
         end
         S_YONE: begin
            if (n_neg) begin
               alu_b = NW'(DAYS_YEAR + int'(leap_dec));
            end else begin
               alu_b            = NW'(DAYS_YEAR + int'(leap_cur));
               alu_ctl.subtract = 1'b1;
            end
         end
         S_MON: begin
            alu_b            = NW'(month_len(m_ff, leap_cur));
            alu_ctl.subtract = 1'b1;
         end
         default: begin
            alu_b            = '0;
            alu_ctl.subtract = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      year_in     = year_ff;
      mon_in      = mon_ff;
      day_in      = day_ff;
      off_in      = off_ff;
      n_in        = n_ff;
      pos_in      = pos_ff;
      m_in        = m_ff;
      res_year_in = res_year_ff;
      res_mon_in  = res_mon_ff;
      res_day_in  = res_day_ff;
      res_inv_in  = res_inv_ff;
      res_rng_in  = res_rng_ff;
      rsp_year_in = rsp_year_ff;
      rsp_mon_in  = rsp_mon_ff;
      rsp_day_in  = rsp_day_ff;
      rsp_inv_in  = rsp_inv_ff;
      rsp_rng_in  = rsp_rng_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               year_in  = YW'(req_tdata[13:0]);
               mon_in   = req_tdata[17:14];
               day_in   = req_tdata[22:18];
               off_in   = req_tdata[22+OFFSET_BITS:23];
               n_in     = NW'(req_tdata[13:0]);
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (!alu_flags.neg) begin
               n_in = alu_sum;
            end else begin
               pos_in   = n_ff[CYCLE_W-1:0];
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (date_ok) begin
               // start one below so that adding the day gives day - 1
               n_in     = '1;
               m_in     = month_type'(1);
               state_in = S_DOY;
            end else begin
               // bad month or day: pass the date through
               res_year_in = year_ff[YEAR_FIELD_W-1:0];
               res_mon_in  = mon_ff;
               res_day_in  = day_ff;
               res_inv_in  = 1'b1;
               res_rng_in  = 1'b0;
               state_in    = S_EMIT;
            end
         end
         S_DOY: begin
            n_in = alu_sum;
            if (m_ff < mon_ff) begin
               m_in = m_ff + 1'b1;
            end else begin
               state_in = S_OFF;
            end
         end
         S_OFF: begin
            n_in     = alu_sum;
            state_in = S_YBIG;
         end
         S_YBIG: begin
            if (n_neg) begin
               if ((year_ff >= YW'(YEARS_CYCLE)) && alu_flags.neg) begin
                  n_in    = alu_sum;
                  year_in = year_ff - YW'(YEARS_CYCLE);
               end else begin
                  state_in = S_YONE;
               end
            end else if (!alu_flags.neg) begin
               if (over_cycle) begin
                  res_year_in = YEAR_FIELD_W'(YEAR_MAX);
                  res_mon_in  = month_type'(MONTHS_PER_YEAR);
                  res_day_in  = day_type'(DAYS_LONG);
                  res_inv_in  = 1'b0;
                  res_rng_in  = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  n_in    = alu_sum;
                  year_in = year_ff + YW'(YEARS_CYCLE);
               end
            end else begin
               state_in = S_YONE;
            end
         end
         S_YONE: begin
            if (n_neg) begin
               if (year_ff == '0) begin
                  // before the first day of year zero
                  res_year_in = '0;
                  res_mon_in  = month_type'(1);
                  res_day_in  = day_type'(1);
                  res_inv_in  = 1'b0;
                  res_rng_in  = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  n_in    = alu_sum;
                  year_in = year_ff - 1'b1;
                  pos_in  = pos_dec;
               end
            end else if (!alu_flags.neg) begin
               if (over_one) begin
                  res_year_in = YEAR_FIELD_W'(YEAR_MAX);
                  res_mon_in  = month_type'(MONTHS_PER_YEAR);
                  res_day_in  = day_type'(DAYS_LONG);
                  res_inv_in  = 1'b0;
                  res_rng_in  = 1'b1;
                  state_in    = S_EMIT;
               end else begin
                  n_in    = alu_sum;
                  year_in = year_ff + 1'b1;
                  pos_in  = pos_inc;
               end
            end else if (over_top) begin
               // start year already above the top and not brought back
               res_year_in = YEAR_FIELD_W'(YEAR_MAX);
               res_mon_in  = month_type'(MONTHS_PER_YEAR);
               res_day_in  = day_type'(DAYS_LONG);
               res_inv_in  = 1'b0;
               res_rng_in  = 1'b1;
               state_in    = S_EMIT;
            end else begin
               m_in     = month_type'(1);
               state_in = S_MON;
            end
         end
         S_MON: begin
            if ((m_ff < month_type'(MONTHS_PER_YEAR)) && !alu_flags.neg) begin
               n_in = alu_sum;
               m_in = m_ff + 1'b1;
            end else begin
               res_year_in = year_ff[YEAR_FIELD_W-1:0];
               res_mon_in  = m_ff;
               res_day_in  = n_ff[DAY_W-1:0] + 1'b1;
               res_inv_in  = 1'b0;
               res_rng_in  = 1'b0;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_year_in  = res_year_ff;
               rsp_mon_in   = res_mon_ff;
               rsp_day_in   = res_day_ff;
               rsp_inv_in   = res_inv_ff;
               rsp_rng_in   = res_rng_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      year_ff     <= year_in;
      mon_ff      <= mon_in;
      day_ff      <= day_in;
      off_ff      <= off_in;
      n_ff        <= n_in;
      pos_ff      <= pos_in;
      m_ff        <= m_in;
      res_year_ff <= res_year_in;
      res_mon_ff  <= res_mon_in;
      res_day_ff  <= res_day_in;
      res_inv_ff  <= res_inv_in;
      res_rng_ff  <= res_rng_in;
      rsp_year_ff <= rsp_year_in;
      rsp_mon_ff  <= rsp_mon_in;
      rsp_day_ff  <= rsp_day_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_rng_ff  <= rsp_rng_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_day_ff, rsp_mon_ff, rsp_year_ff};
   assign rsp_tuser  = {rsp_rng_ff, rsp_inv_ff};

   // a transaction never carries both flags
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("invalid and range flags both set");

   // a good result has a real month and day
   a_result_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         (rsp_tdata[17:14] >= 4'd1 && rsp_tdata[17:14] <= 4'd12 && rsp_tdata[22:18] != 5'd0))
      else $error("result month or day out of range");

   // a saturated result is one of the two end dates
   a_saturated_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |->
         ((rsp_tdata[13:0] == '0 && rsp_tdata[17:14] == 4'd1 && rsp_tdata[22:18] == 5'd1) ||
          (rsp_tdata[13:0] == YEAR_FIELD_W'(YEAR_MAX) && rsp_tdata[17:14] == 4'd12 &&
           rsp_tdata[22:18] == 5'd31)))
      else $error("saturated result is not an end date");

   // the cycle position stays inside the 400-year cycle once formed
   a_cycle_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && state_ff != S_MOD) |-> (pos_ff < cycle_pos_type'(YEARS_CYCLE)))
      else $error("cycle position out of range");

endmodule

/* design/cdad_alu.sv */
module cdad_alu #(
   parameter int W = 20
) (
   input  logic signed [W-1:0]  op_a,
   input  logic signed [W-1:0]  op_b,
   input  cdad_pkg::alu_ctl_type   ctl,
   output logic signed [W-1:0]  sum,
   output cdad_pkg::alu_flags_type flags
);
   import cdad_pkg::*;

   logic signed [W-1:0] b_eff;

   assign b_eff      = ctl.subtract ? ~op_b : op_b;
   assign sum        = op_a + b_eff + W'(ctl.subtract);
   assign flags.neg  = sum[W-1];

endmodule

/* bench/tb_calendar_date_add_days.sv */
`timescale 1ns / 1ps

module tb_calendar_date_add_days;
   import cdad_pkg::*;

   localparam int OFFSET_W     = 17;
   localparam int LAST_YEAR    = 9999;
   localparam int REQ_W        = ((OFFSET_W + 30) / 8) * 8;
   localparam int RANDOM_ITEMS = 900;
   // worst quiet stretch: the whole walk plus a long stall on either side
   localparam int IDLE_LIMIT   = 6000;
   localparam int DRAIN_CYCLES = 600;
   localparam int MAX_REPORTS  = 40;

   // request transaction, year in the lowest bits as on req_tdata
   typedef struct packed {
      logic signed [OFFSET_W-1:0] offset;
      day_type                    day;
      month_type                  month;
      logic [YEAR_FIELD_W-1:0]    year;
   } start_date_type;

   // response transaction, flags on top so that {rsp_tuser, rsp_tdata[22:0]} maps straight in
   typedef struct packed {
      logic                    range_hit;
      logic                    input_invalid;
      day_type                 day;
      month_type               month;
      logic [YEAR_FIELD_W-1:0] year;
   } moved_date_type;

   // one line of the directed table; want is only used where known is set
   typedef struct packed {
      start_date_type stim;
      logic           known;
      moved_date_type want;
   } plan_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [23:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;

   moved_date_type pending_dates [$];
   int             mismatches   = 0;
   int             results_done = 0;
   int             idle_cycles  = 0;
   int             stall_left   = 0;
   bit             calm         = 1'b0;

   calendar_date_add_days #(
      .OFFSET_BITS (OFFSET_W),
      .YEAR_MAX    (LAST_YEAR)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- date arithmetic

   // proleptic gregorian: every fourth year, centuries only when divisible by 400
   function automatic bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % YEARS_CYCLE == 0);
   endfunction

   // zero for a month code outside 1..12, which marks the date as invalid
   function automatic longint days_in_month(longint y, int m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return DAYS_LONG;
         4, 6, 9, 11:           return DAYS_SHORT;
         2:                     return leap_year(y) ? DAYS_FEB + 1 : DAYS_FEB;
         default:               return 0;
      endcase
   endfunction

   // day number of 1 january of year y, counted from 0000-01-01
   function automatic longint days_before(longint y);
      return DAYS_YEAR * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   // expected response: date to day number, add the offset, back to a date
   function automatic moved_date_type shift_date(start_date_type s);
      moved_date_type r;
      longint         n, last, y;
      int             m;
      r = '0;
      if (s.month < 1 || s.month > MONTHS_PER_YEAR || s.day < 1 ||
          s.day > days_in_month(s.year, s.month)) begin
         // bad month or day: echo the date back and flag it
         r.year          = s.year;
         r.month         = s.month;
         r.day           = s.day;
         r.input_invalid = 1'b1;
         return r;
      end
      y = longint'(s.year);
      n = days_before(y);
      for (m = 1; m < s.month; m++)
         n += days_in_month(y, m);
      n = n + longint'(s.day) - 1 + longint'($signed(s.offset));
      last = days_before(LAST_YEAR + 1) - 1;
      if (n < 0) begin
         // fell before the first representable day
         r.year      = '0;
         r.month     = month_type'(1);
         r.day       = day_type'(1);
         r.range_hit = 1'b1;
      end else if (n > last) begin
         // ran past the last day of the last year, start years above it included
         r.year      = YEAR_FIELD_W'(LAST_YEAR);
         r.month     = month_type'(MONTHS_PER_YEAR);
         r.day       = day_type'(DAYS_LONG);
         r.range_hit = 1'b1;
      end else begin
         // estimate the year from the 400-year cycle, then settle it
         y = (n * YEARS_CYCLE) / DAYS_CYCLE;
         while (days_before(y + 1) <= n)
            y++;
         while (y > 0 && days_before(y) > n)
            y--;
         n -= days_before(y);
         m = 1;
         while (m < MONTHS_PER_YEAR && n >= days_in_month(y, m)) begin
            n -= days_in_month(y, m);
            m++;
         end
         r.year  = YEAR_FIELD_W'(y);
         r.month = month_type'(m);
         r.day   = day_type'(n + 1);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic plan_row_type free_row(int y, int m, int d, int off);
      plan_row_type row;
      row              = '0;
      row.stim.year    = YEAR_FIELD_W'(y);
      row.stim.month   = month_type'(m);
      row.stim.day     = day_type'(d);
      row.stim.offset  = OFFSET_W'(off);
      return row;
   endfunction

   function automatic plan_row_type known_row(int y, int m, int d, int off,
                                              int ry, int rm, int rd, bit inv, bit rng);
      plan_row_type row;
      row                    = free_row(y, m, d, off);
      row.known              = 1'b1;
      row.want.year          = YEAR_FIELD_W'(ry);
      row.want.month         = month_type'(rm);
      row.want.day           = day_type'(rd);
      row.want.input_invalid = inv;
      row.want.range_hit     = rng;
      return row;
   endfunction

   // mostly short pauses, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return $urandom_range(3, 1);
      else if (r < 92)
         return $urandom_range(15, 4);
      else
         return $urandom_range(200, 40);
   endfunction

   // mostly well-formed dates, weighted towards the edges of the calendar
   function automatic start_date_type random_start();
      start_date_type s;
      int             pick, v;
      longint         len;
      pick = $urandom_range(19);
      if (pick == 0)
         s.year = YEAR_FIELD_W'($urandom_range(16383, LAST_YEAR + 1));
      else if (pick <= 2)
         s.year = YEAR_FIELD_W'($urandom_range(3, 0));
      else if (pick <= 4)
         s.year = YEAR_FIELD_W'($urandom_range(LAST_YEAR, LAST_YEAR - 3));
      else if (pick <= 6)
         s.year = YEAR_FIELD_W'(100 * $urandom_range(99, 0));
      else
         s.year = YEAR_FIELD_W'($urandom_range(LAST_YEAR, 0));

      if ($urandom_range(9) != 0)
         s.month = month_type'($urandom_range(MONTHS_PER_YEAR, 1));
      else
         s.month = month_type'($urandom_range(15, 0));

      len  = days_in_month(s.year, s.month);
      pick = $urandom_range(19);
      if (len == 0 || pick == 0)
         s.day = day_type'($urandom_range(31, 0));
      else if (pick == 1 || (pick == 2 && len == DAYS_LONG))
         s.day = '0;
      else if (pick == 2)
         s.day = day_type'($urandom_range(31, int'(len) + 1));
      else if (pick <= 5)
         s.day = day_type'(len);
      else
         s.day = day_type'($urandom_range(int'(len), 1));

      pick = $urandom_range(9);
      if (pick <= 2)
         v = $urandom();
      else if (pick <= 5)
         v = $urandom_range(800) - 400;
      else if (pick <= 7) begin
         v = $urandom_range(1500, 365);
         if ($urandom_range(1) == 0)
            v = -v;
      end else if (pick == 8)
         v = 65535 - $urandom_range(200);
      else
         v = -65536 + $urandom_range(200);
      s.offset = OFFSET_W'(v);
      return s;
   endfunction

   // one request transaction, with an optional pause before it; the expectation
   // is queued once the handshake has gone through
   task automatic send_date(start_date_type s, moved_date_type want);
      int gap;
      gap = (!calm && $urandom_range(2) == 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(s);
      do @(posedge clock); while (!req_tready);
      pending_dates.push_back(want);
   endtask

   initial begin
      plan_row_type   plan [$];
      start_date_type s;

      // extremes, saturation both ways and every kind of bad date have known answers
      plan.push_back(known_row(2000, 1, 1, 0,           2000, 1, 1, 0, 0));
      plan.push_back(known_row(0, 1, 1, -1,             0, 1, 1, 0, 1));
      plan.push_back(known_row(0, 1, 1, -65536,         0, 1, 1, 0, 1));
      plan.push_back(known_row(9999, 12, 31, 1,         9999, 12, 31, 0, 1));
      plan.push_back(known_row(9999, 12, 31, 65535,     9999, 12, 31, 0, 1));
      plan.push_back(known_row(2023, 0, 10, 5,          2023, 0, 10, 1, 0));
      plan.push_back(known_row(2023, 13, 1, 100,        2023, 13, 1, 1, 0));
      plan.push_back(known_row(16383, 15, 31, -1,       16383, 15, 31, 1, 0));
      plan.push_back(known_row(2023, 3, 0, 1,           2023, 3, 0, 1, 0));
      plan.push_back(known_row(2023, 4, 31, -1,         2023, 4, 31, 1, 0));
      plan.push_back(known_row(2023, 2, 29, 0,          2023, 2, 29, 1, 0));
      plan.push_back(known_row(1900, 2, 29, 1,          1900, 2, 29, 1, 0));
      plan.push_back(known_row(16383, 12, 31, 0,        9999, 12, 31, 0, 1));
      plan.push_back(known_row(12000, 6, 15, -65536,    9999, 12, 31, 0, 1));
      plan.push_back(known_row(0, 3, 1, -61,            0, 1, 1, 0, 1));
      // the rest go through the predictor
      plan.push_back(free_row(0, 3, 1, -60));
      plan.push_back(free_row(10100, 1, 1, -65536));
      plan.push_back(free_row(2000, 2, 29, 1));
      plan.push_back(free_row(2024, 2, 28, 1));
      plan.push_back(free_row(2100, 2, 28, 1));
      plan.push_back(free_row(2023, 12, 31, 1));
      plan.push_back(free_row(2024, 3, 1, -1));
      plan.push_back(free_row(2000, 1, 1, 65535));
      plan.push_back(free_row(2000, 1, 1, -65536));
      plan.push_back(free_row(9999, 12, 31, -65536));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         send_date(plan[i].stim, plan[i].known ? plan[i].want : shift_date(plan[i].stim));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // every 200 transactions a stretch of 50 with no pauses on either side
         calm <= (i % 200) >= 150;
         s = random_start();
         send_date(s, shift_date(s));
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      while (pending_dates.size() != 0)
         @(posedge clock);
      // catch any stray response still to come
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // backpressure: random stalls of random length, none during calm stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(3) == 0)
            stall_left <= idle_length();
      end
   end

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_REPORTS)
         $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // compare each response transaction with the oldest pending date
   always @(posedge clock) begin
      moved_date_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = moved_date_type'({rsp_tuser, rsp_tdata[22:0]});
         if (pending_dates.size() == 0)
            report_mismatch($sformatf("response %0d arrived with nothing pending",
                                      results_done));
         else begin
            want = pending_dates.pop_front();
            if (got.year != want.year)
               report_mismatch($sformatf("response %0d year %0d, want %0d",
                                         results_done, got.year, want.year));
            if (got.month != want.month)
               report_mismatch($sformatf("response %0d month %0d, want %0d",
                                         results_done, got.month, want.month));
            if (got.day != want.day)
               report_mismatch($sformatf("response %0d day %0d, want %0d",
                                         results_done, got.day, want.day));
            if (got.input_invalid != want.input_invalid)
               report_mismatch($sformatf("response %0d input_invalid %0b, want %0b",
                                         results_done, got.input_invalid,
                                         want.input_invalid));
            if (got.range_hit != want.range_hit)
               report_mismatch($sformatf("response %0d range_hit %0b, want %0b",
                                         results_done, got.range_hit, want.range_hit));
         end
         results_done++;
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
